[src/spmh_pkg.sv]
// shared types, constants, ordering function and microcode rom of the heap unit
`default_nettype none

package spmh_pkg;

    localparam int CAPACITY = 255;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STEP_W   = 4;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        logic        [15:0] id;
        logic signed [15:0] prio;
        logic        [31:0] stamp;
    } t_entry;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // datapath operations
    typedef enum logic [3:0] {
        D_NONE,
        D_LOAD,
        D_INS_START,
        D_EXT_START,
        D_EXT_TAKE,
        D_MOVE_PARENT,
        D_MOVE_CHILD,
        D_PLACE,
        D_POST
    } t_dop;

    // memory read selection
    typedef enum logic [1:0] {
        RD_NONE,
        RD_UP,
        RD_EXT,
        RD_DOWN
    } t_rd;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_IF,
        J_DISPATCH,
        J_WAIT_OUT
    } t_jmp;

    typedef enum logic [1:0] {
        C_POS_ROOT,
        C_NOT_ABOVE,
        C_LEFT_BEYOND,
        C_BEST_CUR
    } t_cond;

    typedef struct packed {
        t_jmp  jmp;
        t_cond cond;
        t_step target;
        t_dop  dop;
        t_rd   rd;
    } t_uword;

    typedef struct packed {
        t_dop dop;
        t_rd  rd;
        logic go;
    } t_ctl;

    typedef struct packed {
        logic op;
        logic full;
        logic empty;
        logic pos_root;
        logic not_above;
        logic left_beyond;
        logic best_cur;
        logic out_busy;
    } t_flags;

    // step addresses of the microprogram
    localparam t_step STP_IDLE     = 4'd0;
    localparam t_step STP_INS      = 4'd1;
    localparam t_step STP_UP_READ  = 4'd2;
    localparam t_step STP_UP_CMP   = 4'd3;
    localparam t_step STP_UP_MOVE  = 4'd4;
    localparam t_step STP_PLACE    = 4'd5;
    localparam t_step STP_FINISH   = 4'd6;
    localparam t_step STP_EXT      = 4'd7;
    localparam t_step STP_EXT_TAKE = 4'd8;
    localparam t_step STP_DN_READ  = 4'd9;
    localparam t_step STP_DN_CMP   = 4'd10;
    localparam t_step STP_DN_MOVE  = 4'd11;

    // larger priority wins, then the smaller stamp
    function automatic logic ranks_above(input t_entry a, input t_entry b);
        logic res;
        if (a.prio != b.prio) begin
            res = (a.prio > b.prio);
        end else begin
            res = (a.stamp < b.stamp);
        end
        return res;
    endfunction

    function automatic t_uword mk(input t_jmp j, input t_cond c, input t_step t,
                                  input t_dop d, input t_rd r);
        t_uword w;
        w.jmp    = j;
        w.cond   = c;
        w.target = t;
        w.dop    = d;
        w.rd     = r;
        return w;
    endfunction

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            STP_IDLE:     w = mk(J_DISPATCH, C_POS_ROOT, STP_IDLE, D_LOAD, RD_NONE);
            STP_INS:      w = mk(J_GOTO, C_POS_ROOT, STP_UP_READ, D_INS_START, RD_NONE);
            STP_UP_READ:  w = mk(J_IF, C_POS_ROOT, STP_PLACE, D_NONE, RD_UP);
            STP_UP_CMP:   w = mk(J_IF, C_NOT_ABOVE, STP_PLACE, D_NONE, RD_NONE);
            STP_UP_MOVE:  w = mk(J_GOTO, C_POS_ROOT, STP_UP_READ, D_MOVE_PARENT, RD_NONE);
            STP_PLACE:    w = mk(J_NEXT, C_POS_ROOT, STP_IDLE, D_PLACE, RD_NONE);
            STP_FINISH:   w = mk(J_WAIT_OUT, C_POS_ROOT, STP_IDLE, D_POST, RD_NONE);
            STP_EXT:      w = mk(J_NEXT, C_POS_ROOT, STP_IDLE, D_EXT_START, RD_EXT);
            STP_EXT_TAKE: w = mk(J_NEXT, C_POS_ROOT, STP_IDLE, D_EXT_TAKE, RD_NONE);
            STP_DN_READ:  w = mk(J_IF, C_LEFT_BEYOND, STP_PLACE, D_NONE, RD_DOWN);
            STP_DN_CMP:   w = mk(J_IF, C_BEST_CUR, STP_PLACE, D_NONE, RD_NONE);
            STP_DN_MOVE:  w = mk(J_GOTO, C_POS_ROOT, STP_DN_READ, D_MOVE_CHILD, RD_NONE);
            default:      w = mk(J_GOTO, C_POS_ROOT, STP_IDLE, D_NONE, RD_NONE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[src/spmh_seq.sv]
// microcode sequencer: step counter, rom lookup and jump logic
`default_nettype none

module spmh_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire spmh_pkg::t_flags i_flags,
    output logic                 o_in_ready,
    output spmh_pkg::t_ctl       o_ctl
);

    spmh_pkg::t_step  r_step;
    spmh_pkg::t_step  n_step;
    spmh_pkg::t_uword uw;
    logic             cond_hit;

    assign uw = spmh_pkg::ucode(r_step);

    always_comb begin
        unique case (uw.cond)
            spmh_pkg::C_POS_ROOT:    cond_hit = i_flags.pos_root;
            spmh_pkg::C_NOT_ABOVE:   cond_hit = i_flags.not_above;
            spmh_pkg::C_LEFT_BEYOND: cond_hit = i_flags.left_beyond;
            spmh_pkg::C_BEST_CUR:    cond_hit = i_flags.best_cur;
            default:                 cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_step    = r_step + spmh_pkg::t_step'(1);
        o_ctl.go  = 1'b1;
        o_ctl.dop = uw.dop;
        o_ctl.rd  = uw.rd;
        unique case (uw.jmp)
            spmh_pkg::J_NEXT: begin
                n_step = r_step + spmh_pkg::t_step'(1);
            end
            spmh_pkg::J_GOTO: begin
                n_step = uw.target;
            end
            spmh_pkg::J_IF: begin
                if (cond_hit) begin
                    n_step = uw.target;
                end
            end
            spmh_pkg::J_DISPATCH: begin
                o_ctl.go = i_in_valid;
                if (!i_in_valid) begin
                    n_step = r_step;
                end else if (i_flags.op == spmh_pkg::OP_INSERT) begin
                    n_step = i_flags.full ? spmh_pkg::STP_FINISH : spmh_pkg::STP_INS;
                end else begin
                    n_step = i_flags.empty ? spmh_pkg::STP_FINISH : spmh_pkg::STP_EXT;
                end
            end
            spmh_pkg::J_WAIT_OUT: begin
                // hold until the output register can take the word
                o_ctl.go = !i_flags.out_busy;
                n_step   = i_flags.out_busy ? r_step : uw.target;
            end
            default: begin
                n_step = spmh_pkg::STP_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_step == spmh_pkg::STP_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= spmh_pkg::STP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

[src/spmh_dp.sv]
// heap datapath: entry memory, position and count registers, compare and output register
`default_nettype none

module spmh_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire spmh_pkg::t_ctl     i_ctl,
    input  wire logic               i_operation,
    input  wire logic        [15:0] i_entry_id,
    input  wire logic signed [15:0] i_priority_req,
    input  wire logic               i_out_ready,
    output spmh_pkg::t_flags        o_flags,
    output logic                    o_out_valid,
    output logic             [1:0]  o_status,
    output logic             [15:0] o_out_id,
    output logic signed      [15:0] o_out_priority,
    output logic             [31:0] o_out_stamp,
    output logic             [7:0]  o_occupancy
);

    localparam int CW = spmh_pkg::CNT_W;

    spmh_pkg::t_entry  mem [0:spmh_pkg::CAPACITY];

    spmh_pkg::t_cnt    r_count;
    logic     [31:0]   r_stamp_ctr;
    spmh_pkg::t_cnt    r_pos;
    spmh_pkg::t_entry  r_cur;
    spmh_pkg::t_entry  r_top;
    spmh_pkg::t_status r_status;
    spmh_pkg::t_entry  r_rd_a;
    spmh_pkg::t_entry  r_rd_b;
    logic              r_out_valid;
    logic     [1:0]    r_o_status;
    spmh_pkg::t_entry  r_o_entry;
    logic     [7:0]    r_o_occ;

    spmh_pkg::t_cnt    parent;
    logic     [CW:0]   left_w;
    logic     [CW:0]   right_w;
    spmh_pkg::t_cnt    ra;
    spmh_pkg::t_cnt    rb;
    logic              left_above;
    logic              right_ok;
    logic              pick_right;
    spmh_pkg::t_entry  best;
    spmh_pkg::t_cnt    best_pos;
    logic              wr_en;
    spmh_pkg::t_entry  wr_data;
    logic              go;

    assign go      = i_ctl.go;
    assign parent  = r_pos >> 1;
    assign left_w  = {r_pos, 1'b0};
    assign right_w = {r_pos, 1'b1};

    always_comb begin
        ra = parent;
        rb = r_count;
        unique case (i_ctl.rd)
            spmh_pkg::RD_UP: begin
                ra = parent;
            end
            spmh_pkg::RD_EXT: begin
                ra = spmh_pkg::t_cnt'(1);
                rb = r_count;
            end
            spmh_pkg::RD_DOWN: begin
                ra = left_w[CW-1:0];
                rb = right_w[CW-1:0];
            end
            default: begin
                ra = parent;
            end
        endcase
    end

    // pick the child that must rise, if any
    always_comb begin
        left_above = spmh_pkg::ranks_above(r_rd_a, r_cur);
        right_ok   = (right_w <= {1'b0, r_count});
        pick_right = right_ok &&
                     spmh_pkg::ranks_above(r_rd_b, left_above ? r_rd_a : r_cur);
        best       = pick_right ? r_rd_b : r_rd_a;
        best_pos   = pick_right ? right_w[CW-1:0] : left_w[CW-1:0];
    end

    assign o_flags.op          = i_operation;
    assign o_flags.full        = (r_count >= spmh_pkg::t_cnt'(spmh_pkg::CAPACITY));
    assign o_flags.empty       = (r_count == '0);
    assign o_flags.pos_root    = (r_pos == spmh_pkg::t_cnt'(1));
    assign o_flags.not_above   = !spmh_pkg::ranks_above(r_cur, r_rd_a);
    assign o_flags.left_beyond = (left_w > {1'b0, r_count});
    assign o_flags.best_cur    = !left_above && !pick_right;
    assign o_flags.out_busy    = r_out_valid && !i_out_ready;

    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_cur;
        unique case (i_ctl.dop)
            spmh_pkg::D_MOVE_PARENT: begin
                wr_en   = 1'b1;
                wr_data = r_rd_a;
            end
            spmh_pkg::D_MOVE_CHILD: begin
                wr_en   = 1'b1;
                wr_data = best;
            end
            spmh_pkg::D_PLACE: begin
                wr_en   = 1'b1;
                wr_data = r_cur;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pos] <= wr_data;
        end
        if (i_ctl.rd != spmh_pkg::RD_NONE) begin
            r_rd_a <= mem[ra];
            r_rd_b <= mem[rb];
        end
    end

    // payload and position registers
    always_ff @(posedge i_clk) begin
        if (go) begin
            case (i_ctl.dop)
                spmh_pkg::D_LOAD: begin
                    r_cur.id    <= i_entry_id;
                    r_cur.prio  <= i_priority_req;
                    r_cur.stamp <= r_stamp_ctr;
                    r_top       <= '0;
                    if (i_operation == spmh_pkg::OP_INSERT && o_flags.full) begin
                        r_status <= spmh_pkg::ST_FULL;
                    end else if (i_operation == spmh_pkg::OP_EXTRACT && o_flags.empty) begin
                        r_status <= spmh_pkg::ST_EMPTY;
                    end else begin
                        r_status <= spmh_pkg::ST_OK;
                    end
                end
                spmh_pkg::D_INS_START: begin
                    r_pos <= r_count + spmh_pkg::t_cnt'(1);
                end
                spmh_pkg::D_EXT_START: begin
                    r_pos <= spmh_pkg::t_cnt'(1);
                end
                spmh_pkg::D_EXT_TAKE: begin
                    r_top <= r_rd_a;
                    r_cur <= r_rd_b;
                end
                spmh_pkg::D_MOVE_PARENT: begin
                    r_pos <= parent;
                end
                spmh_pkg::D_MOVE_CHILD: begin
                    r_pos <= best_pos;
                end
                spmh_pkg::D_POST: begin
                    r_o_status <= r_status;
                    r_o_entry  <= r_top;
                    r_o_occ    <= 8'(r_count);
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_stamp_ctr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (go && (i_ctl.dop == spmh_pkg::D_POST)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (go) begin
                case (i_ctl.dop)
                    spmh_pkg::D_INS_START: begin
                        r_count     <= r_count + spmh_pkg::t_cnt'(1);
                        r_stamp_ctr <= r_stamp_ctr + 32'd1;
                    end
                    spmh_pkg::D_EXT_START: begin
                        r_count <= r_count - spmh_pkg::t_cnt'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_out_id       = r_o_entry.id;
    assign o_out_priority = r_o_entry.prio;
    assign o_out_stamp    = r_o_entry.stamp;
    assign o_occupancy    = r_o_occ;

endmodule

`default_nettype wire

[src/stable_max_priority_heap_unit.sv]
// top level of the stable max-priority heap unit
// usage:
//   input channel (i_in_valid / o_in_ready) carries one word: i_operation selects insert
//   or extract, i_entry_id and i_priority_req are stored on insert and ignored on extract
//   output channel (o_out_valid / i_out_ready) returns one word per input word: status,
//   the extracted entry (id, priority, arrival stamp; zero for inserts and errors) and
//   the occupancy after the operation
// timing:
//   one word at a time; the sequencer steps once per cycle through a microprogram, unless
//   it waits for an input word or the output register; insert: load, start, then per level
//   the new entry climbs a memory read, a compare and a write on the single write port of
//   the entry memory (up to 7 levels), a final read plus a compare if it stops below the
//   root, then place and finish; extract: load, start, take, the same per-level steps as
//   the moved entry sinks (up to 7 levels), a final read plus a compare if it stops above
//   the bottom level, then place and finish; full or empty errors: load, then finish
// reset: entry count and arrival counter clear at once, no clearing pass over the memory;
//   entries beyond the count are never used
// stall: the result sits in an output register; while the receiver holds i_out_ready
//   low with a word pending, the sequencer waits at its final step and takes no new word
`default_nettype none

module stable_max_priority_heap_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_operation,
    input  wire logic        [15:0] i_entry_id,
    input  wire logic signed [15:0] i_priority_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [1:0]  o_status,
    output logic             [15:0] o_out_id,
    output logic signed      [15:0] o_out_priority,
    output logic             [31:0] o_out_stamp,
    output logic             [7:0]  o_occupancy
);

    // control word from the rom and status flags back from the datapath
    spmh_pkg::t_ctl   ctl;
    spmh_pkg::t_flags flags;

    spmh_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_in_ready (o_in_ready),
        .o_ctl      (ctl)
    );

    // entry memory, sift registers and the output register
    spmh_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_operation    (i_operation),
        .i_entry_id     (i_entry_id),
        .i_priority_req (i_priority_req),
        .i_out_ready    (i_out_ready),
        .o_flags        (flags),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_out_stamp    (o_out_stamp),
        .o_occupancy    (o_occupancy)
    );

endmodule

`default_nettype wire

[tb/tb_stable_max_priority_heap_unit.sv]
// testbench for the stable max-priority heap unit with a self-checking heap scoreboard
`timescale 1ns / 100ps

// one expected output word
typedef struct {
    spmh_pkg::t_status  status;
    logic        [15:0] id;
    logic signed [15:0] prio;
    logic        [31:0] stamp;
    logic        [7:0]  occupancy;
} t_heap_result;

// heap model plus the queue of output words it still owes
class priority_heap_checker;
    spmh_pkg::t_entry slots [0:spmh_pkg::CAPACITY];
    int unsigned      held;
    logic [31:0]      next_stamp;
    t_heap_result     awaited_results [$];
    int               mismatches;

    function new();
        held       = 0;
        next_stamp = '0;
        mismatches = 0;
    endfunction

    function void note_error(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // higher priority first, older stamp breaks ties
    function bit outranks(spmh_pkg::t_entry a, spmh_pkg::t_entry b);
        return (a.prio > b.prio) || ((a.prio == b.prio) && (a.stamp < b.stamp));
    endfunction

    function void swap(int unsigned x, int unsigned y);
        spmh_pkg::t_entry tmp;
        tmp      = slots[x];
        slots[x] = slots[y];
        slots[y] = tmp;
    endfunction

    function void climb(int unsigned pos);
        while (pos > 1 && outranks(slots[pos], slots[pos / 2])) begin
            swap(pos, pos / 2);
            pos = pos / 2;
        end
    endfunction

    function void sink(int unsigned pos);
        int unsigned kid;
        int unsigned best;
        forever begin
            best = pos;
            kid  = 2 * pos;
            if (kid <= held && outranks(slots[kid], slots[best])) begin
                best = kid;
            end
            if (kid + 1 <= held && outranks(slots[kid + 1], slots[best])) begin
                best = kid + 1;
            end
            if (best == pos) break;
            swap(pos, best);
            pos = best;
        end
    endfunction

    // accepted input word: update the heap and queue the word it must produce
    function void take_word(logic op, logic [15:0] id, logic signed [15:0] prio);
        t_heap_result r;
        r.status = spmh_pkg::ST_OK;
        r.id     = '0;
        r.prio   = '0;
        r.stamp  = '0;
        if (op == spmh_pkg::OP_INSERT) begin
            if (held >= spmh_pkg::CAPACITY) begin
                r.status = spmh_pkg::ST_FULL;
            end else begin
                held++;
                slots[held].id    = id;
                slots[held].prio  = prio;
                slots[held].stamp = next_stamp;
                next_stamp        = next_stamp + 32'd1;
                climb(held);
            end
        end else if (held == 0) begin
            r.status = spmh_pkg::ST_EMPTY;
        end else begin
            r.id     = slots[1].id;
            r.prio   = slots[1].prio;
            r.stamp  = slots[1].stamp;
            slots[1] = slots[held];
            held--;
            if (held > 1) sink(1);
        end
        r.occupancy = 8'(held);
        awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            note_error($sformatf("mismatch %s: expected %0h, got %0h", name, want, got));
        end
    endfunction

    function void check_result(logic [1:0] status, logic [15:0] id,
                               logic signed [15:0] prio, logic [31:0] stamp,
                               logic [7:0] occupancy);
        t_heap_result want;
        if (awaited_results.size() == 0) begin
            note_error($sformatf("unexpected word: status %0h id %0h", status, id));
            return;
        end
        want = awaited_results.pop_front();
        compare_field("status",    32'(want.status),          32'(status));
        compare_field("id",        32'(want.id),              32'(id));
        compare_field("priority",  32'(16'(want.prio)),       32'(16'(prio)));
        compare_field("stamp",     want.stamp,                stamp);
        compare_field("occupancy", 32'(want.occupancy),       32'(occupancy));
    endfunction

    function void flag_leftovers();
        if (awaited_results.size() != 0) begin
            note_error($sformatf("%0d words never arrived", awaited_results.size()));
        end
    endfunction
endclass

module tb_stable_max_priority_heap_unit;

    // cycles with no handshake on either channel before the run is declared hung;
    // the slowest word plus gaps and the deliberate receiver hold are far shorter
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    // drain time after the last word, above the longest extract
    localparam int SETTLE_CYCLES  = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_operation;
    logic        [15:0] i_entry_id;
    logic signed [15:0] i_priority_req;
    logic               o_out_valid;
    logic               i_out_ready;
    logic        [1:0]  o_status;
    logic        [15:0] o_out_id;
    logic signed [15:0] o_out_priority;
    logic        [31:0] o_out_stamp;
    logic        [7:0]  o_occupancy;

    priority_heap_checker heap_chk = new();

    // idle control shared between the sender, the receiver and the main sequence
    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    int long_hold     = 0;

    stable_max_priority_heap_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_entry_id     (i_entry_id),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_out_stamp    (o_out_stamp),
        .o_occupancy    (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one word, holding it until accepted; a zero gap keeps valid high
    // without dropping it, so back-to-back words need one assignment per edge
    task automatic send_word(input logic op, input logic [15:0] id,
                             input logic signed [15:0] prio);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_entry_id     <= id;
        i_priority_req <= prio;
        do @(posedge i_clk); while (!o_in_ready);
        heap_chk.take_word(op, id, prio);
    endtask

    // mostly full-range priorities, with tie-heavy and extreme values mixed in
    function automatic logic signed [15:0] pick_priority(bit narrow);
        int sel;
        sel = narrow ? 1 : $urandom_range(0, 3);
        case (sel)
            1: return 16'(int'($urandom_range(0, 6)) - 3);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return -16'sd1;
                    default: return 16'sd0;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int count, input int insert_pct, input bit narrow);
        logic op;
        repeat (count) begin
            op = ($urandom_range(0, 99) < insert_pct) ? spmh_pkg::OP_INSERT
                                                       : spmh_pkg::OP_EXTRACT;
            send_word(op, 16'($urandom), pick_priority(narrow));
        end
    endtask

    task automatic wait_drained();
        while (heap_chk.awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // directed opening: empty extract, field extremes, ties at the top, bottom
    // and middle of the range, then a full drain back to empty
    task automatic directed_checks();
        send_word(spmh_pkg::OP_EXTRACT, 16'hFFFF, 16'sh7FFF);
        send_word(spmh_pkg::OP_INSERT,  16'hFFFF, 16'sh7FFF);
        send_word(spmh_pkg::OP_INSERT,  16'h0000, 16'sh8000);
        send_word(spmh_pkg::OP_INSERT,  16'h1234, 16'sd0);
        send_word(spmh_pkg::OP_INSERT,  16'h0001, 16'sd0);
        send_word(spmh_pkg::OP_INSERT,  16'h8000, -16'sd1);
        send_word(spmh_pkg::OP_INSERT,  16'h5555, 16'sh7FFF);
        send_word(spmh_pkg::OP_INSERT,  16'hAAAA, 16'sh8000);
        repeat (8) send_word(spmh_pkg::OP_EXTRACT, 16'($urandom), 16'($urandom));
        // equal priorities must come back in arrival order
        send_word(spmh_pkg::OP_INSERT, 16'h0A0A, 16'sd5);
        send_word(spmh_pkg::OP_INSERT, 16'h0B0B, 16'sd5);
        send_word(spmh_pkg::OP_INSERT, 16'h0C0C, 16'sd5);
        repeat (3) send_word(spmh_pkg::OP_EXTRACT, 16'h0000, 16'sd0);
    endtask

    // receiver: random stall before each word, or the long hold when requested
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold != 0) begin
                stall     = long_hold;
                long_hold = 0;
            end else begin
                stall = receiver_gaps ? $urandom_range(0, 5) : 0;
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            heap_chk.check_result(o_status, o_out_id, o_out_priority, o_out_stamp,
                                  o_occupancy);
        end
    end

    // watchdog: ends the run when no word moves on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_operation    <= spmh_pkg::OP_INSERT;
        i_entry_id     <= '0;
        i_priority_req <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_checks();

        // fill past capacity so full inserts occur
        run_phase(340, 95, 1'b0);
        // balanced traffic around a long receiver hold; input backs up meanwhile
        run_phase(250, 50, 1'b0);
        long_hold = LONG_HOLD;
        run_phase(250, 50, 1'b0);
        // back-to-back stretch, no idling on either side
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        run_phase(300, 50, 1'b0);
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        // sender pauses until every outstanding word is back
        i_in_valid <= 1'b0;
        wait_drained();
        // drain to empty so empty extracts occur
        run_phase(350, 10, 1'b0);
        // tie-heavy priorities to exercise stamp ordering in both sifts
        run_phase(160, 50, 1'b1);

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        heap_chk.flag_leftovers();
        if (heap_chk.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[stable_max_priority_heap_unit.f]
src/spmh_pkg.sv
src/spmh_seq.sv
src/spmh_dp.sv
src/stable_max_priority_heap_unit.sv
tb/tb_stable_max_priority_heap_unit.sv
